/* rtl/lbk_pkg.sv */
// Package for the LB_Keogh early-abandon block: widths, payload types,
// the lane control struct and the envelope excess function. No dependencies.
package lbk_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_WIDTH    = 48;
    localparam int REG_WIDTH    = 48;
    localparam int BOUND_WIDTH  = 48;
    localparam int SQ_WIDTH     = 2 * SAMPLE_WIDTH;
    localparam int ACC_WIDTH    = ((SUM_WIDTH > SQ_WIDTH) ? SUM_WIDTH : SQ_WIDTH) + 1;
    localparam int CMP_WIDTH    = (SUM_WIDTH > REG_WIDTH) ? SUM_WIDTH : REG_WIDTH;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic        [SAMPLE_WIDTH-1:0] t_diff;
    typedef logic        [SQ_WIDTH-1:0]     t_sq;
    typedef logic        [SUM_WIDTH-1:0]    t_sum;
    typedef logic        [REG_WIDTH-1:0]    t_thr;
    typedef logic        [BOUND_WIDTH-1:0]  t_bound;

    localparam t_sum SUM_MAX = {SUM_WIDTH{1'b1}};

    // Pipeline control shared by both lanes.
    typedef struct packed {
        logic advance;
        logic s2_valid;
        logic s2_last;
    } t_pipe_ctl;

    // Distance of a sample outside its envelope. The upper test wins when the
    // envelope is inverted. Values are compared in offset-binary form.
    function automatic t_diff excess(input t_sample x, input t_sample lo,
                                     input t_sample hi);
        t_diff bx;
        t_diff bl;
        t_diff bh;
        t_diff d;
        bx = {~x[SAMPLE_WIDTH-1], x[SAMPLE_WIDTH-2:0]};
        bl = {~lo[SAMPLE_WIDTH-1], lo[SAMPLE_WIDTH-2:0]};
        bh = {~hi[SAMPLE_WIDTH-1], hi[SAMPLE_WIDTH-2:0]};
        if (bx > bh) begin
            d = bx - bh;
        end else if (bx < bl) begin
            d = bl - bx;
        end else begin
            d = '0;
        end
        return d;
    endfunction

    // True while a sum is still below the abandon threshold, or always when the threshold is infinite.
    function automatic logic sum_below(input t_sum s, input t_thr thr,
                                       input logic infinite);
        return infinite || (CMP_WIDTH'(s) < CMP_WIDTH'(thr));
    endfunction

endpackage

/* rtl/lbk_in_if.sv */
// Input channel interface: one beat carries an aligned sample pair, both
// envelopes and the last flag. Depends on lbk_pkg.
interface lbk_in_if import lbk_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_a;
    t_sample lower_b;
    t_sample upper_b;
    t_sample sample_b;
    t_sample lower_a;
    t_sample upper_a;
    logic    last;

    modport source (output valid, sample_a, lower_b, upper_b, sample_b, lower_a,
                    upper_a, last, input ready);
    modport sink   (input valid, sample_a, lower_b, upper_b, sample_b, lower_a,
                    upper_a, last, output ready);
endinterface

/* rtl/lbk_out_if.sv */
// Result channel interface: one beat carries the bound and the pruned flag.
// Depends on lbk_pkg.
interface lbk_out_if import lbk_pkg::*; ();
    logic   valid;
    logic   ready;
    t_bound bound;
    logic   pruned;

    modport source (output valid, bound, pruned, input ready);
    modport sink   (input valid, bound, pruned, output ready);
endinterface

/* rtl/lbk_lane.sv */
// One accumulation lane: envelope excess, square, saturating accumulate with
// early abandon, and a register for the final sum of a series. Uses lbk_pkg.
module lbk_lane import lbk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_sample   i_sample,
    input  t_sample   i_lower,
    input  t_sample   i_upper,
    input  t_thr      i_threshold,
    input  logic      i_infinite,
    output t_sum      o_final_sum
);

    t_diff r_diff;
    t_sq   r_sq;
    t_sum  r_sum;
    t_sum  r_final;
    t_sum  n_sum;

    logic [ACC_WIDTH-1:0] acc_wide;

    always_comb begin
        acc_wide = ACC_WIDTH'(r_sum) + ACC_WIDTH'(r_sq);
        if (!sum_below(r_sum, i_threshold, i_infinite)) begin
            n_sum = r_sum;
        end else if (acc_wide > ACC_WIDTH'(SUM_MAX)) begin
            n_sum = SUM_MAX;
        end else begin
            n_sum = SUM_WIDTH'(acc_wide);
        end
    end

    // Payload stages need no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_diff <= excess(i_sample, i_lower, i_upper);
            r_sq   <= SQ_WIDTH'(r_diff) * SQ_WIDTH'(r_diff);
        end
        if (i_ctl.advance && i_ctl.s2_valid && i_ctl.s2_last) begin
            r_final <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.advance && i_ctl.s2_valid) begin
            r_sum <= i_ctl.s2_last ? '0 : n_sum;
        end
    end

    assign o_final_sum = r_final;

endmodule

/* rtl/lbk_merge.sv */
// Merge stage: combines the two final lane sums into the bound and the pruned
// flag and holds them in the output register. Uses lbk_pkg.
module lbk_merge import lbk_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_sum   i_fwd,
    input  t_sum   i_bwd,
    input  t_thr   i_threshold,
    input  logic   i_infinite,
    input  logic   i_ready,
    output logic   o_valid,
    output t_bound o_bound,
    output logic   o_pruned
);

    logic   r_valid;
    t_bound r_bound;
    logic   r_pruned;
    logic   n_pruned;
    t_sum   n_max;

    always_comb begin
        n_pruned = !sum_below(i_fwd, i_threshold, i_infinite);
        n_max    = (i_fwd > i_bwd) ? i_fwd : i_bwd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pruned <= n_pruned;
            r_bound  <= n_pruned ? BOUND_WIDTH'(SUM_MAX) : BOUND_WIDTH'(n_max);
        end
    end

    assign o_valid  = r_valid;
    assign o_bound  = r_bound;
    assign o_pruned = r_pruned;

endmodule

/* rtl/cross_lb_keogh_early_abandon.sv */
// Top level of the symmetric LB_Keogh lower bound with early abandoning.
// Depends on lbk_pkg, lbk_in_if, lbk_out_if, lbk_lane and lbk_merge.

// The block takes one beat per clock, each carrying one aligned index of two
// series: both samples and the envelope of each series at that index. A
// forward lane adds the squared excess of sample_a over the envelope of the
// second series and a backward lane does the same for sample_b against the
// envelope of the first; each lane stops adding once its sum reaches the
// dropout threshold, and each sum saturates at all ones. The beat flagged
// last closes a series: its result moves through the excess, square and
// final-sum stages to the output register and carries the larger of the
// two sums, or all ones with pruned set when the forward sum reached the
// threshold; a threshold of all ones means no abandoning at all. The rate
// is one beat per clock, set by the accumulate loop in each lane; the
// input stalls only when a finished result reaches the merge stage while
// the previous result still sits unclaimed in the output register. The
// threshold should be written only while no series is in flight.
module cross_lb_keogh_early_abandon import lbk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  t_thr      i_cfg_wdata,
    lbk_in_if.sink    i_in,
    lbk_out_if.source o_res
);

    // Threshold register and its precomputed "infinite" flag.
    t_thr r_threshold;
    logic r_infinite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '1;
            r_infinite  <= 1'b1;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
            r_infinite  <= CMP_WIDTH'(i_cfg_wdata) >= CMP_WIDTH'(SUM_MAX);
        end
    end

    // Pipeline control. Stage one holds the excess, stage two the square, and
    // stage three the final sums of a closed series waiting for the merge.
    logic r_s1_valid;
    logic r_s1_last;
    logic r_s2_valid;
    logic r_s2_last;
    logic r_s3_valid;

    logic      advance;
    logic      accept;
    logic      res_valid;
    t_pipe_ctl ctl;
    t_sum      fwd_final;
    t_sum      bwd_final;

    // The whole pipeline moves together. It holds only when a result is ready
    // to merge and the output register is full and not being drained.
    assign advance  = !(r_s3_valid && res_valid && !o_res.ready);
    assign i_in.ready = advance;
    assign accept   = i_in.valid && advance;

    assign ctl.advance  = advance;
    assign ctl.s2_valid = r_s2_valid;
    assign ctl.s2_last  = r_s2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_last  <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept;
            r_s1_last  <= i_in.last;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_s3_valid <= r_s2_valid && r_s2_last;
        end
    end

    lbk_lane u_fwd_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_in.sample_a),
        .i_lower     (i_in.lower_b),
        .i_upper     (i_in.upper_b),
        .i_threshold (r_threshold),
        .i_infinite  (r_infinite),
        .o_final_sum (fwd_final)
    );

    lbk_lane u_bwd_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_in.sample_b),
        .i_lower     (i_in.lower_a),
        .i_upper     (i_in.upper_a),
        .i_threshold (r_threshold),
        .i_infinite  (r_infinite),
        .o_final_sum (bwd_final)
    );

    // A waiting stage-three result moves into the output register whenever
    // the pipeline advances, which means the register is free or draining.
    lbk_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (r_s3_valid && advance),
        .i_fwd       (fwd_final),
        .i_bwd       (bwd_final),
        .i_threshold (r_threshold),
        .i_infinite  (r_infinite),
        .i_ready     (o_res.ready),
        .o_valid     (res_valid),
        .o_bound     (o_res.bound),
        .o_pruned    (o_res.pruned)
    );

    assign o_res.valid = res_valid;

endmodule

/* verif/cross_lb_keogh_early_abandon_tb.sv */
// Self-checking testbench for cross_lb_keogh_early_abandon: directed and random
// series, threshold changes between phases, random gaps and output stalls.
// Depends on lbk_pkg, lbk_in_if, lbk_out_if and the block's RTL.
`timescale 1ns / 1ps

module cross_lb_keogh_early_abandon_tb;
    import lbk_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_SERIES  = 40;

    // One input beat: the forward lane sees sample_a against the envelope of
    // the second series, the backward lane sample_b against the first.
    typedef struct {
        t_sample sample_a;
        t_sample lower_b;
        t_sample upper_b;
        t_sample sample_b;
        t_sample lower_a;
        t_sample upper_a;
        logic    last;
    } t_beat;

    typedef struct {
        t_bound bound;
        logic   pruned;
    } t_lb_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_thr i_cfg_wdata;

    lbk_in_if  in_bus ();
    lbk_out_if res_bus ();

    cross_lb_keogh_early_abandon dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_res       (res_bus)
    );

    // Beats waiting to be driven, and bounds waiting to come out.
    t_beat      pending_beats[$];
    t_lb_result expected_bounds[$];
    t_beat      drive_beat;

    // Predictor state: the two lane sums and the threshold the block holds.
    t_sum fwd_sum_model;
    t_sum bwd_sum_model;
    t_thr thr_model;

    int sent_cnt;
    int taken_cnt;
    int mismatch_cnt;
    int cycle_cnt;
    int gap_pct;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Every input of the block starts at a known value.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_bus.valid     = 1'b0;
        in_bus.sample_a  = '0;
        in_bus.lower_b   = '0;
        in_bus.upper_b   = '0;
        in_bus.sample_b  = '0;
        in_bus.lower_a   = '0;
        in_bus.upper_a   = '0;
        in_bus.last      = 1'b0;
        res_bus.ready    = 1'b0;
        sent_cnt         = 0;
        taken_cnt        = 0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        gap_pct          = 38;
        stall_pct        = 38;
        fwd_sum_model    = '0;
        bwd_sum_model    = '0;
        thr_model        = SUM_MAX;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Squared distance of a sample outside its envelope. The upper bound is
    // tested first, so an inverted envelope counts against upper whenever the
    // sample is above it, and against lower only otherwise.
    function automatic longint unsigned squared_excess(input t_sample x, input t_sample lo,
                                                       input t_sample hi);
        int d;
        if (x > hi) begin
            d = int'(x) - int'(hi);
        end else if (x < lo) begin
            d = int'(lo) - int'(x);
        end else begin
            d = 0;
        end
        return longint'(d) * longint'(d);
    endfunction

    // Lane sums stick at all ones instead of wrapping.
    function automatic t_sum saturating_add(input t_sum s, input longint unsigned add);
        longint unsigned total;
        total = longint'(s) + add;
        if (total > longint'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return t_sum'(total);
    endfunction

    // Advances both lane sums by one accepted beat and, on the last beat of a
    // series, queues the bound that the block should report.
    task automatic accumulate_lb_keogh(input t_beat b);
        logic       no_abandon;
        t_lb_result r;
        no_abandon = (thr_model == SUM_MAX);
        if (no_abandon || fwd_sum_model < thr_model) begin
            fwd_sum_model = saturating_add(fwd_sum_model,
                                           squared_excess(b.sample_a, b.lower_b, b.upper_b));
        end
        if (no_abandon || bwd_sum_model < thr_model) begin
            bwd_sum_model = saturating_add(bwd_sum_model,
                                           squared_excess(b.sample_b, b.lower_a, b.upper_a));
        end
        if (b.last) begin
            // Only the forward lane decides pruning; an abandoned backward lane
            // still contributes its partial sum to the maximum.
            r.pruned = !(no_abandon || fwd_sum_model < thr_model);
            if (r.pruned) begin
                r.bound = SUM_MAX;
            end else if (fwd_sum_model > bwd_sum_model) begin
                r.bound = fwd_sum_model;
            end else begin
                r.bound = bwd_sum_model;
            end
            expected_bounds.insert(expected_bounds.size(), r);
            fwd_sum_model = '0;
            bwd_sum_model = '0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------

    // The input beat is held until it is taken; a new beat goes out only
    // after the previous one was accepted, and then only if the random gap
    // does not fall on this cycle. The result side stalls independently.
    always @(negedge i_clk) begin
        if (in_bus.valid && sent_cnt != taken_cnt) begin
            // Still waiting for the block to take the current beat.
        end else if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
            drive_beat       = pending_beats.pop_front();
            in_bus.valid    <= 1'b1;
            in_bus.sample_a <= drive_beat.sample_a;
            in_bus.lower_b  <= drive_beat.lower_b;
            in_bus.upper_b  <= drive_beat.upper_b;
            in_bus.sample_b <= drive_beat.sample_b;
            in_bus.lower_a  <= drive_beat.lower_a;
            in_bus.upper_a  <= drive_beat.upper_a;
            in_bus.last     <= drive_beat.last;
            sent_cnt++;
        end else begin
            in_bus.valid <= 1'b0;
        end
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Input beats are predicted before results are checked, so the order of
    // the two sides within one edge never matters to the result queue.
    always @(posedge i_clk) begin
        t_lb_result want;
        if (in_bus.valid && in_bus.ready) begin
            taken_cnt++;
            accumulate_lb_keogh(drive_beat);
        end
        if (res_bus.valid && res_bus.ready) begin
            if (expected_bounds.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected, bound %0d pruned %0b",
                                          res_bus.bound, res_bus.pruned));
            end else begin
                want = expected_bounds.pop_front();
                if (res_bus.bound !== want.bound) begin
                    report_mismatch($sformatf("bound %0d, expected %0d",
                                              res_bus.bound, want.bound));
                end
                if (res_bus.pruned !== want.pruned) begin
                    report_mismatch($sformatf("pruned %0b, expected %0b",
                                              res_bus.pruned, want.pruned));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("cross_lb_keogh_early_abandon test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Appends one beat to the end of the pending queue.
    task automatic queue_beat(input t_beat b);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    function automatic t_sample clamp_sample(input int v);
        if (v > 32767) begin
            return t_sample'(32767);
        end
        if (v < -32768) begin
            return t_sample'(-32768);
        end
        return t_sample'(v);
    endfunction

    function automatic t_beat mk_beat(input int a, input int lb, input int ub, input int b,
                                      input int la, input int ua, input logic is_last);
        t_beat bt;
        bt.sample_a = t_sample'(a);
        bt.lower_b  = t_sample'(lb);
        bt.upper_b  = t_sample'(ub);
        bt.sample_b = t_sample'(b);
        bt.lower_a  = t_sample'(la);
        bt.upper_a  = t_sample'(ua);
        bt.last     = is_last;
        return bt;
    endfunction

    // Mostly an ordered envelope around a random center with the sample
    // landing inside or somewhat outside it; now and then raw noise, which
    // also gives inverted envelopes and the largest excesses.
    task automatic shape_lane(output t_sample x, output t_sample lo, output t_sample hi);
        int c;
        int w;
        int off;
        if ($urandom_range(99) < 15) begin
            x  = t_sample'($urandom);
            lo = t_sample'($urandom);
            hi = t_sample'($urandom);
        end else begin
            c   = int'($urandom_range(65535)) - 32768;
            w   = $urandom_range(800);
            off = int'($urandom_range(2 * w + 3000)) - (w + 1500);
            lo  = clamp_sample(c - w);
            hi  = clamp_sample(c + w);
            x   = clamp_sample(c + off);
        end
    endtask

    task automatic push_random_beat(input logic is_last);
        t_beat bt;
        shape_lane(bt.sample_a, bt.lower_b, bt.upper_b);
        shape_lane(bt.sample_b, bt.lower_a, bt.upper_a);
        bt.last = is_last;
        queue_beat(bt);
    endtask

    // Waits until every beat was taken and every bound came back, then lets
    // the pipeline settle before anything else touches the block.
    task automatic wait_drained();
        while (!(pending_beats.size() == 0 && sent_cnt == taken_cnt
                 && expected_bounds.size() == 0)) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input t_thr v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_model    = v;
    endtask

    // A series of the largest excess on both lanes, so the sums grow by the
    // largest step on every beat.
    task automatic queue_max_excess_series();
        for (int k = 0; k < LONG_SERIES; k++) begin
            queue_beat(mk_beat(32767, -32768, -32768, -32768, 32767, 32767,
                               k == LONG_SERIES - 1));
        end
    endtask

    initial begin
        t_thr thr;
        int   n;
        int   len;
        int   r;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset threshold is all ones, so nothing is abandoned here.
        // Largest excess on both lanes as a series of one beat.
        queue_beat(mk_beat(32767, -32768, -32768, -32768, 32767, 32767, 1'b1));
        // Largest excess the other way, then a beat inside both envelopes.
        queue_beat(mk_beat(-32768, 32767, 32767, 32767, -32768, -32768, 1'b0));
        queue_beat(mk_beat(0, -1, 1, 0, 0, 0, 1'b1));
        // Inverted envelopes: one sample above upper, the other below lower
        // but not above upper.
        queue_beat(mk_beat(0, 100, -100, -200, 100, -100, 1'b1));
        // Ordinary below-lower and above-upper cases.
        queue_beat(mk_beat(-300, -100, 100, 500, -100, 100, 1'b0));
        queue_beat(mk_beat(77, 70, 70, -4, -3, 12, 1'b1));
        wait_drained();

        // Zero threshold: a zero sum is already at the threshold, so every
        // series comes back pruned.
        set_threshold('0);
        queue_beat(mk_beat(5, 0, 0, 5, 0, 0, 1'b0));
        queue_beat(mk_beat(0, 0, 0, 0, 0, 0, 1'b1));
        queue_beat(mk_beat(0, 0, 0, 0, 0, 0, 1'b1));
        wait_drained();

        // Small threshold: backward lane abandons while forward stays in
        // range, forward crossing on one beat, staying just below, and
        // crossing on the second beat.
        set_threshold(t_thr'(1000));
        queue_beat(mk_beat(0, -10, 10, 1000, 0, 0, 1'b0));
        queue_beat(mk_beat(0, -10, 10, 1000, 0, 0, 1'b0));
        queue_beat(mk_beat(0, -10, 10, 5, 0, 0, 1'b1));
        queue_beat(mk_beat(40, -10, 0, 0, 0, 0, 1'b1));
        queue_beat(mk_beat(31, -10, 0, 0, 0, 0, 1'b1));
        queue_beat(mk_beat(31, -10, 0, 0, 0, 0, 1'b0));
        queue_beat(mk_beat(31, -10, 0, 0, 0, 0, 1'b1));
        wait_drained();

        // One below all ones is a real threshold that these series stay far
        // below, so nothing is pruned. This stretch runs with no gaps and no
        // stalls.
        gap_pct   = 0;
        stall_pct = 0;
        set_threshold(SUM_MAX - 1);
        queue_beat(mk_beat(32767, -32768, -32768, 0, 0, 0, 1'b1));
        queue_max_excess_series();
        wait_drained();

        // All ones written explicitly: no abandoning, pruned stays clear.
        gap_pct   = 38;
        stall_pct = 38;
        set_threshold(SUM_MAX);
        queue_max_excess_series();
        wait_drained();

        // Random phases, each under its own threshold. Thresholds are mostly
        // in the range where well-formed series cross them part way through.
        for (int ph = 0; ph < 8; ph++) begin
            r = $urandom_range(9);
            if (r == 0) begin
                thr = SUM_MAX;
            end else if (r == 1) begin
                thr = t_thr'({$urandom, $urandom}) >> $urandom_range(0, 47);
            end else begin
                thr = t_thr'({$urandom, $urandom}) >> $urandom_range(16, 32);
            end
            gap_pct   = (ph == 5) ? 0 : 38;
            stall_pct = (ph == 5) ? 0 : 38;
            set_threshold(thr);
            n = 0;
            while (n < 190) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    push_random_beat(k == len - 1);
                end
                n += len;
            end
            wait_drained();
        end

        if (mismatch_cnt == 0) begin
            $display("cross_lb_keogh_early_abandon test passed");
        end else begin
            $display("cross_lb_keogh_early_abandon test failed");
        end
        $finish;
    end

endmodule
